/* hw/rtl/assert_macros.svh */
// Assertion helpers for the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is held off while reset is asserted.
`define SABG_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion that is also checked across reset.
`define SABG_ASSERT_ANY(name, clk, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hw/rtl/sabg_pkg.sv */
// ----------------------------------------------------------------------------
// sabg_pkg
// Shared widths, register index codes and sideband type of the snow albedo
// pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package sabg_pkg;

    localparam int unsigned DAY_W = 32;
    localparam int unsigned COS_W = 16;
    localparam int unsigned RAD_W = 24;
    localparam int unsigned ALB_W = 16;
    localparam int unsigned DEN_W = 58;
    localparam int unsigned Q_W   = 17;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STORM_DAY = 3'd0,
        CFG_IR_BASE   = 3'd1,
        CFG_IR_SPAN   = 3'd2,
        CFG_VIS_BASE  = 3'd3,
        CFG_VIS_SPAN  = 3'd4
    } t_cfg_idx;

    // Flags and the 1 - cos(zenith) weight that ride along with each request.
    typedef struct packed {
        logic             err;
        logic             sun_down;
        logic [COS_W-1:0] w;
    } t_side;

endpackage

`default_nettype wire

/* hw/rtl/snow_albedo_from_grain_growth.sv */
// The block takes one record per clock unless a stall holds it (sample day
// in Q16.16 and the cosine of the solar zenith angle in Q1.15) and returns
// visible and infrared snow albedo in Q2.14 plus a flag for a sample day
// before the storm day, one result per record. The path runs through the
// 17-stage restoring divider for the grain growth factor, framed by three
// front stages and seven albedo stages. Every stage holds its request
// while the one after it is full, so a stall on the output loses nothing and
// the input keeps accepting as long as any stage has room.
// ----------------------------------------------------------------------------
// snow_albedo_from_grain_growth
// Streaming snow albedo from grain growth since the last storm.
// ----------------------------------------------------------------------------
`default_nettype none

module snow_albedo_from_grain_growth #(
    parameter int unsigned EXP_TABLE_ENTRIES = 256
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [31:0] sample_day, [47:32] zenith_cosine
    input  wire logic [47:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [15:0] visible_albedo, [31:16] infrared_albedo
    output logic [31:0]      m_axis_tdata,
    // [0] time_error
    output logic             m_axis_tuser,
    input  wire logic        i_cfg_we,
    input  wire logic [sabg_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [sabg_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import sabg_pkg::*;

    logic [DAY_W-1:0] r_storm_day;
    logic [RAD_W-1:0] r_ir_base_radius;
    logic [RAD_W-1:0] r_ir_radius_span;
    logic [RAD_W-1:0] r_vis_base_radius;
    logic [RAD_W-1:0] r_vis_radius_span;

    logic             fr_valid, fr_ready;
    logic [DEN_W-1:0] fr_num, fr_den;
    t_side            fr_side;
    logic             dv_valid, dv_ready;
    logic [Q_W-1:0]   dv_quot;
    t_side            dv_side;
    logic [ALB_W-1:0] vis_albedo, ir_albedo;
    logic             time_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_storm_day       <= '0;
            r_ir_base_radius  <= '0;
            r_ir_radius_span  <= '0;
            r_vis_base_radius <= '0;
            r_vis_radius_span <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_STORM_DAY: r_storm_day       <= i_cfg_data;
                CFG_IR_BASE:   r_ir_base_radius  <= i_cfg_data[RAD_W-1:0];
                CFG_IR_SPAN:   r_ir_radius_span  <= i_cfg_data[RAD_W-1:0];
                CFG_VIS_BASE:  r_vis_base_radius <= i_cfg_data[RAD_W-1:0];
                CFG_VIS_SPAN:  r_vis_radius_span <= i_cfg_data[RAD_W-1:0];
                default: begin
                end
            endcase
        end
    end

    sabg_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (s_axis_tvalid),
        .o_ready         (s_axis_tready),
        .i_sample_day    (s_axis_tdata[31:0]),
        .i_zenith_cosine (s_axis_tdata[47:32]),
        .i_storm_day     (r_storm_day),
        .o_valid         (fr_valid),
        .i_ready         (fr_ready),
        .o_num           (fr_num),
        .o_den           (fr_den),
        .o_side          (fr_side)
    );

    sabg_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (fr_valid),
        .o_ready (fr_ready),
        .i_num   (fr_num),
        .i_den   (fr_den),
        .i_side  (fr_side),
        .o_valid (dv_valid),
        .i_ready (dv_ready),
        .o_quot  (dv_quot),
        .o_side  (dv_side)
    );

    sabg_albedo #(
        .EXP_TABLE_ENTRIES (EXP_TABLE_ENTRIES)
    ) u_albedo (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (dv_valid),
        .o_ready           (dv_ready),
        .i_quot            (dv_quot),
        .i_side            (dv_side),
        .i_ir_base_radius  (r_ir_base_radius),
        .i_ir_radius_span  (r_ir_radius_span),
        .i_vis_base_radius (r_vis_base_radius),
        .i_vis_radius_span (r_vis_radius_span),
        .o_valid           (m_axis_tvalid),
        .i_ready           (m_axis_tready),
        .o_visible_albedo  (vis_albedo),
        .o_infrared_albedo (ir_albedo),
        .o_time_error      (time_err)
    );

    assign m_axis_tdata = {ir_albedo, vis_albedo};
    assign m_axis_tuser = time_err;

endmodule

`default_nettype wire

/* hw/rtl/sabg_front.sv */
// ----------------------------------------------------------------------------
// sabg_front
// Elapsed time, time error and sun flags, then numerator and denominator of
// the grain growth quotient over three register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module sabg_front (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output logic                                o_ready,
    input  wire logic [sabg_pkg::DAY_W-1:0]     i_sample_day,
    input  wire logic signed [sabg_pkg::COS_W-1:0] i_zenith_cosine,
    input  wire logic [sabg_pkg::DAY_W-1:0]     i_storm_day,
    output logic                                o_valid,
    input  wire logic                           i_ready,
    output logic [sabg_pkg::DEN_W-1:0]          o_num,
    output logic [sabg_pkg::DEN_W-1:0]          o_den,
    output sabg_pkg::t_side                     o_side
);
    import sabg_pkg::*;

    localparam int unsigned NS  = 3;
    localparam int unsigned T_W = 29;

    logic          r_v [NS];
    logic          go  [NS+1];

    logic [DAY_W:0]   n_diff;
    logic [T_W-1:0]   n_t;
    t_side            n_side;

    logic [T_W-1:0]   r0_t;
    t_side            r0_side;
    logic [DEN_W-1:0] r1_tt;
    logic [DEN_W-1:0] r1_lin;
    logic [T_W-1:0]   r1_tp;
    t_side            r1_side;
    logic [DEN_W-1:0] r2_num;
    logic [DEN_W-1:0] r2_den;
    t_side            r2_side;

    assign go[NS] = i_ready;
    for (genvar k = 0; k < NS; k++) begin : g_go
        assign go[k] = !r_v[k] || go[k+1];
    end

    always_comb begin
        n_diff = {1'b0, i_sample_day} - {1'b0, i_storm_day};
        // t in Q.12 is the elapsed time plus one day.
        n_t = {1'b0, n_diff[DAY_W-1:4]} + T_W'(4096);
        n_side.err = n_diff[DAY_W];
        n_side.sun_down = (i_zenith_cosine == '0) || i_zenith_cosine[COS_W-1];
        n_side.w = COS_W'(17'h08000 - {1'b0, i_zenith_cosine});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
            r_v[1] <= 1'b0;
            r_v[2] <= 1'b0;
        end else begin
            if (go[0]) r_v[0] <= i_valid;
            if (go[1]) r_v[1] <= r_v[0];
            if (go[2]) r_v[2] <= r_v[1];
        end
        if (go[0]) begin
            r0_t    <= n_t;
            r0_side <= n_side;
        end
        if (go[1]) begin
            r1_tt   <= {{T_W{1'b0}}, r0_t} * {{T_W{1'b0}}, r0_t};
            r1_lin  <= ({{T_W{1'b0}}, r0_t} << 12) + DEN_W'(2 << 24);
            r1_tp   <= r0_t + T_W'(4096);
            r1_side <= r0_side;
        end
        if (go[2]) begin
            r2_den  <= r1_tt + r1_lin;
            r2_num  <= {r1_tp, {(DEN_W-T_W){1'b0}}};
            r2_side <= r1_side;
        end
    end

    assign o_ready = go[0];
    assign o_valid = r_v[NS-1];
    assign o_num   = r2_num;
    assign o_den   = r2_den;
    assign o_side  = r2_side;

endmodule

`default_nettype wire

/* hw/rtl/sabg_div.sv */
// ----------------------------------------------------------------------------
// sabg_div
// Pipelined restoring divider, one quotient bit per stage, for the grain
// growth quotient. The quotient never exceeds 65536.
// ----------------------------------------------------------------------------
`default_nettype none

module sabg_div (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_valid,
    output logic                         o_ready,
    input  wire logic [sabg_pkg::DEN_W-1:0] i_num,
    input  wire logic [sabg_pkg::DEN_W-1:0] i_den,
    input  sabg_pkg::t_side              i_side,
    output logic                         o_valid,
    input  wire logic                    i_ready,
    output logic [sabg_pkg::Q_W-1:0]     o_quot,
    output sabg_pkg::t_side              o_side
);
    import sabg_pkg::*;

    localparam int unsigned TR_W = DEN_W + Q_W + 1;

    logic             r_v    [Q_W];
    logic             go     [Q_W+1];
    logic [DEN_W-1:0] r_rem  [Q_W];
    logic [DEN_W-1:0] r_den  [Q_W];
    logic [Q_W-1:0]   r_q    [Q_W];
    t_side            r_side [Q_W];

    assign go[Q_W] = i_ready;

    for (genvar j = 0; j < Q_W; j++) begin : g_stage
        localparam int unsigned K = Q_W - 1 - j;

        logic             v_in;
        logic [DEN_W-1:0] rem_in;
        logic [DEN_W-1:0] den_in;
        logic [Q_W-1:0]   q_in;
        t_side            side_in;
        logic [TR_W-1:0]  trial;

        if (j == 0) begin : g_first
            assign v_in    = i_valid;
            assign rem_in  = i_num;
            assign den_in  = i_den;
            assign q_in    = '0;
            assign side_in = i_side;
        end else begin : g_next
            assign v_in    = r_v[j-1];
            assign rem_in  = r_rem[j-1];
            assign den_in  = r_den[j-1];
            assign q_in    = r_q[j-1];
            assign side_in = r_side[j-1];
        end

        assign go[j] = !r_v[j] || go[j+1];
        // The top bit is the borrow: set when the remainder is below den << K.
        assign trial = {{(Q_W+1){1'b0}}, rem_in} - ({{(Q_W+1){1'b0}}, den_in} << K);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[j] <= 1'b0;
            end else if (go[j]) begin
                r_v[j] <= v_in;
            end
            if (go[j]) begin
                r_den[j]  <= den_in;
                r_side[j] <= side_in;
                if (!trial[TR_W-1]) begin
                    r_rem[j] <= trial[DEN_W-1:0];
                    r_q[j]   <= {q_in[Q_W-2:0], 1'b1};
                end else begin
                    r_rem[j] <= rem_in;
                    r_q[j]   <= {q_in[Q_W-2:0], 1'b0};
                end
            end
        end
    end

    assign o_ready = go[0];
    assign o_valid = r_v[Q_W-1];
    assign o_quot  = r_q[Q_W-1];
    assign o_side  = r_side[Q_W-1];

endmodule

`default_nettype wire

/* hw/rtl/sabg_albedo.sv */
// ----------------------------------------------------------------------------
// sabg_albedo
// Grain radii from the growth factor, visible albedo, interpolated infrared
// exponential and final rounding, over seven register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module sabg_albedo #(
    parameter int unsigned EXP_TABLE_ENTRIES = 256
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    output logic                            o_ready,
    input  wire logic [sabg_pkg::Q_W-1:0]   i_quot,
    input  sabg_pkg::t_side                 i_side,
    input  wire logic [sabg_pkg::RAD_W-1:0] i_ir_base_radius,
    input  wire logic [sabg_pkg::RAD_W-1:0] i_ir_radius_span,
    input  wire logic [sabg_pkg::RAD_W-1:0] i_vis_base_radius,
    input  wire logic [sabg_pkg::RAD_W-1:0] i_vis_radius_span,
    output logic                            o_valid,
    input  wire logic                       i_ready,
    output logic [sabg_pkg::ALB_W-1:0]      o_visible_albedo,
    output logic [sabg_pkg::ALB_W-1:0]      o_infrared_albedo,
    output logic                            o_time_error
);
    import sabg_pkg::*;

    localparam int unsigned NS    = 7;
    localparam int unsigned AW    = $clog2(EXP_TABLE_ENTRIES + 1);
    localparam int unsigned G_W   = RAD_W + 1;
    localparam int unsigned P_W   = G_W + AW;
    localparam logic [AW-1:0] N_ADDR = AW'(EXP_TABLE_ENTRIES);
    localparam logic [63:0] EXP_STEP = (64'd22795539 << 9) / EXP_TABLE_ENTRIES;
    localparam logic [20:0] VZRG  = 21'd1476395;
    localparam logic [21:0] IRZRG = 22'd2147484;
    localparam logic [31:0] IRZ0  = 32'd107374182;
    localparam logic [33:0] ONE_Q30 = 34'd1073741824;
    // ceil(2^39 / 125): exact floor division by 125 for 32-bit dividends.
    localparam logic [32:0] RECIP_125 = 33'd4398046512;

    typedef logic [29:0] t_rom [0:EXP_TABLE_ENTRIES];

    function automatic t_rom rom_build(input logic [63:0] h);
        t_rom               rom;
        logic [63:0]        term;
        logic [63:0]        v;
        logic signed [63:0] r;
        term = 64'd1073741824;
        r    = 64'sd1073741824;
        v    = 64'd917480176;
        // Decay ratio per table step from its Taylor series.
        for (int k = 1; k <= 20; k++) begin
            term = ((term * h) >> 30) / 64'(k);
            if (k[0]) r = r - $signed(term);
            else      r = r + $signed(term);
        end
        if (r < 0) r = '0;
        for (int i = 0; i <= int'(EXP_TABLE_ENTRIES); i++) begin
            rom[i] = v[29:0];
            v = (v * $unsigned(r) + (64'd1 << 29)) >> 30;
        end
        return rom;
    endfunction

    localparam t_rom EXP_ROM = rom_build(EXP_STEP);

    function automatic logic [ALB_W-1:0] to_q14(input logic [33:0] x);
        logic [33:0] y;
        y = x + 34'd32768;
        if (x[33] || x == '0) return '0;
        if (y[33:32] != 2'b00) return '1;
        return y[31:16];
    endfunction

    logic r_v [NS];
    logic go  [NS+1];

    // Stage 0 signals.
    logic [Q_W-1:0]   n_g;
    logic [40:0]      n_pv_full;
    logic [40:0]      n_pir_full;
    // Stage 2 signals.
    logic [45:0]      n_dzv_full;
    logic [31:0]      n_z;
    logic [64:0]      n_zm;
    logic [46:0]      n_dzir_full;
    logic [P_W-1:0]   n_p;
    logic [AW-1:0]    n_idx;
    logic             n_sat;
    // Stage 3 and 4 signals.
    logic [45:0]      n_dzvw_full;
    logic [47:0]      n_dzirw_full;
    logic [29:0]      n_eb;
    logic [29:0]      n_ediff;
    logic [54:0]      n_eprod;

    logic [RAD_W-1:0] r0_pv, r0_pir;
    t_side            r0_side;
    logic [G_W-1:0]   r1_gv, r1_gir;
    t_side            r1_side;
    logic [29:0]      r2_dzv;
    logic [24:0]      r2_zq;
    logic [G_W-1:0]   r2_gv;
    logic [31:0]      r2_dzir;
    logic [AW-1:0]    r2_addr_a, r2_addr_b;
    logic [24:0]      r2_frac;
    t_side            r2_side;
    logic [30:0]      r3_vq;
    logic [30:0]      r3_dzvw;
    logic [32:0]      r3_dzirw;
    logic [29:0]      r3_ea, r3_eb;
    logic [24:0]      r3_frac;
    t_side            r3_side;
    logic [33:0]      r4_av;
    logic [29:0]      r4_ea;
    logic [29:0]      r4_ecorr;
    logic [32:0]      r4_dzirw;
    t_side            r4_side;
    logic [33:0]      r5_av, r5_ai;
    t_side            r5_side;
    logic [ALB_W-1:0] r6_vis, r6_ir;
    logic             r6_err;

    assign go[NS] = i_ready;
    for (genvar k = 0; k < NS; k++) begin : g_go
        assign go[k] = !r_v[k] || go[k+1];
    end

    always_comb begin
        n_g = Q_W'(17'd65536 - ((i_quot > 17'd65536) ? 17'd65536 : i_quot));
        n_pv_full  = {17'd0, i_vis_radius_span} * {24'd0, n_g};
        n_pir_full = {17'd0, i_ir_radius_span} * {24'd0, n_g};

        n_dzv_full  = {21'd0, r1_gv} * {25'd0, VZRG};
        // (gv << 14) / 500 = 32*gv + floor(96*gv / 125).
        n_z  = ({7'd0, r1_gv} << 6) + ({7'd0, r1_gv} << 5);
        n_zm = {33'd0, n_z} * {32'd0, RECIP_125};
        n_dzir_full = {22'd0, r1_gir} * {25'd0, IRZRG};
        n_p   = {{AW{1'b0}}, r1_gir} * {{G_W{1'b0}}, N_ADDR};
        n_idx = n_p[P_W-1:G_W];
        n_sat = n_idx >= N_ADDR;

        n_dzvw_full  = {16'd0, r2_dzv} * {30'd0, r2_side.w};
        n_dzirw_full = {16'd0, r2_dzir} * {32'd0, r2_side.w};

        n_eb    = (r3_eb > r3_ea) ? r3_ea : r3_eb;
        n_ediff = r3_ea - n_eb;
        n_eprod = {25'd0, n_ediff} * {30'd0, r3_frac};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < int'(NS); k++) r_v[k] <= 1'b0;
        end else begin
            if (go[0]) r_v[0] <= i_valid;
            for (int k = 1; k < int'(NS); k++) begin
                if (go[k]) r_v[k] <= r_v[k-1];
            end
        end

        if (go[0]) begin
            r0_pv   <= n_pv_full[39:16];
            r0_pir  <= n_pir_full[39:16];
            r0_side <= i_side;
        end
        if (go[1]) begin
            r1_gv   <= {1'b0, i_vis_base_radius} + {1'b0, r0_pv};
            r1_gir  <= {1'b0, i_ir_base_radius} + {1'b0, r0_pir};
            r1_side <= r0_side;
        end
        if (go[2]) begin
            r2_dzv    <= n_dzv_full[45:16];
            r2_zq     <= n_zm[63:39];
            r2_gv     <= r1_gv;
            r2_dzir   <= {1'b0, n_dzir_full[46:16]} + IRZ0;
            r2_addr_a <= n_sat ? N_ADDR : n_idx;
            r2_addr_b <= n_sat ? N_ADDR : n_idx + AW'(1);
            r2_frac   <= n_sat ? 25'd0 : n_p[G_W-1:0];
            r2_side   <= r1_side;
        end
        if (go[3]) begin
            r3_vq    <= {1'b0, r2_gv, 5'd0} + {6'd0, r2_zq};
            r3_dzvw  <= n_dzvw_full[45:15];
            r3_dzirw <= n_dzirw_full[47:15];
            r3_ea    <= EXP_ROM[r2_addr_a];
            r3_eb    <= EXP_ROM[r2_addr_b];
            r3_frac  <= r2_frac;
            r3_side  <= r2_side;
        end
        if (go[4]) begin
            r4_av    <= ONE_Q30 - {3'd0, r3_vq} + {3'd0, r3_dzvw};
            r4_ea    <= r3_ea;
            r4_ecorr <= n_eprod[54:25];
            r4_dzirw <= r3_dzirw;
            r4_side  <= r3_side;
        end
        if (go[5]) begin
            r5_av   <= r4_av;
            r5_ai   <= {4'd0, r4_ea} - {4'd0, r4_ecorr} + {1'b0, r4_dzirw};
            r5_side <= r4_side;
        end
        if (go[6]) begin
            if (r5_side.err || r5_side.sun_down) begin
                r6_vis <= '0;
                r6_ir  <= '0;
            end else begin
                r6_vis <= to_q14(r5_av);
                r6_ir  <= to_q14(r5_ai);
            end
            r6_err <= r5_side.err;
        end
    end

    assign o_ready           = go[0];
    assign o_valid           = r_v[NS-1];
    assign o_visible_albedo  = r6_vis;
    assign o_infrared_albedo = r6_ir;
    assign o_time_error      = r6_err;

endmodule

`default_nettype wire

/* hw/rtl/sabg_checker.sv */
// ----------------------------------------------------------------------------
// sabg_checker
// Port-level checks of the snow albedo block, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module sabg_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [31:0] m_axis_tdata,
    input wire logic        m_axis_tuser
);

    // Nothing comes out in the cycle right after reset.
    `SABG_ASSERT(a_empty_after_reset, i_clk, i_rst_n, !$past(i_rst_n) |-> !m_axis_tvalid, "result valid right after reset")

    // With the output stage empty there is room in the pipeline, so input is accepted.
    `SABG_ASSERT(a_ready_when_drained, i_clk, i_rst_n, !m_axis_tvalid |-> s_axis_tready, "input stalled while output empty")

    // A time error forces both albedos to zero.
    `SABG_ASSERT(a_error_zeroes, i_clk, i_rst_n, (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == 32'd0), "albedo nonzero with time error")

    // A stalled result holds.
    `SABG_ASSERT(a_stall_holds, i_clk, i_rst_n, (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)), "stalled result changed")

endmodule

bind snow_albedo_from_grain_growth sabg_checker u_sabg_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
